// ===== hdl/crs_pkg.sv =====
// shared types and constants of the corner response overlap suppression block
`timescale 1ns / 1ps

package crs_pkg;

   localparam int MAX_KEYPOINTS = 1024;
   localparam int ADDR_BITS     = $clog2(MAX_KEYPOINTS);
   localparam int CNT_BITS      = ADDR_BITS + 1;
   localparam int COORD_BITS    = 12;
   localparam int RESP_BITS     = 8;
   localparam int DIAM_BITS     = 6;
   localparam int SQ_BITS       = 2 * DIAM_BITS;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_RESPONSE      = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEYPOINT_DIAMETER = 1'd1;

   localparam logic [RESP_BITS-1:0] MIN_RESPONSE_RESET      = 8'd100;
   localparam logic [DIAM_BITS-1:0] KEYPOINT_DIAMETER_RESET = 6'd6;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      STATUS_ADDED      = 3'd0,
      STATUS_REPLACED   = 3'd1,
      STATUS_SUPPRESSED = 3'd2,
      STATUS_BELOW      = 3'd3,
      STATUS_FULL       = 3'd4,
      STATUS_DONE       = 3'd5
   } status_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [RESP_BITS-1:0]  r;
   } entry_type;

   typedef struct packed {
      logic       walk;
      logic       clear;
      logic       append;
      logic       capture;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       below;
      logic       hit;
      logic       walk_end;
      logic       overlap;
      logic       full;
   } stat_type;

endpackage

// ===== hdl/crs_if.sv =====
// request and result channel interfaces
`timescale 1ns / 1ps

interface crs_req_if import crs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic [RESP_BITS-1:0]  response;
   logic [ADDR_BITS-1:0]  entry_index;

   modport source (output valid, func, pix_x, pix_y, response, entry_index, input ready);
   modport sink (input valid, func, pix_x, pix_y, response, entry_index, output ready);
endinterface

interface crs_rsp_if import crs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            status;
   logic [CNT_BITS-1:0]   kept_count;
   logic                  entry_valid;
   logic [COORD_BITS-1:0] entry_x;
   logic [COORD_BITS-1:0] entry_y;
   logic [RESP_BITS-1:0]  entry_response;

   modport source (output valid, status, kept_count, entry_valid, entry_x, entry_y,
                   entry_response, input ready);
   modport sink (input valid, status, kept_count, entry_valid, entry_x, entry_y,
                 entry_response, output ready);
endinterface

// ===== hdl/crs_ctrl.sv =====
// controller state machine sequencing decode, clear, store walk, append and result
`timescale 1ns / 1ps

module crs_ctrl import crs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_WALK,
      ST_APPEND,
      ST_FINISH
   } state_type;

   state_type  state_ff;
   logic       ready_ff;
   logic       rsp_valid_ff;
   logic       walk_ff;
   logic       clear_ff;
   logic       append_ff;
   status_type code_ff;
   logic       capture;

   // result register takes a new value once the old one has gone out
   assign capture = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= 1'b0;
         clear_ff     <= 1'b0;
         append_ff    <= 1'b0;
         code_ff      <= STATUS_DONE;
      end else begin
         if (capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  ready_ff <= 1'b0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               priority if (st.func == FUNC_SAMPLE && st.below) begin
                  code_ff  <= STATUS_BELOW;
                  state_ff <= ST_FINISH;
               end else if (st.func == FUNC_SAMPLE) begin
                  walk_ff  <= 1'b1;
                  state_ff <= ST_WALK;
               end else if (st.func == FUNC_CLEAR) begin
                  clear_ff <= 1'b1;
                  state_ff <= ST_CLEAR;
               end else begin
                  code_ff  <= STATUS_DONE;
                  state_ff <= ST_FINISH;
               end
            end
            ST_CLEAR: begin
               clear_ff <= 1'b0;
               code_ff  <= STATUS_DONE;
               state_ff <= ST_FINISH;
            end
            ST_WALK: begin
               priority if (st.hit) begin
                  walk_ff  <= 1'b0;
                  code_ff  <= STATUS_REPLACED;
                  state_ff <= ST_FINISH;
               end else if (st.walk_end) begin
                  walk_ff <= 1'b0;
                  priority if (st.overlap) begin
                     code_ff  <= STATUS_SUPPRESSED;
                     state_ff <= ST_FINISH;
                  end else if (st.full) begin
                     code_ff  <= STATUS_FULL;
                     state_ff <= ST_FINISH;
                  end else begin
                     append_ff <= 1'b1;
                     state_ff  <= ST_APPEND;
                  end
               end
            end
            ST_APPEND: begin
               append_ff <= 1'b0;
               code_ff   <= STATUS_ADDED;
               state_ff  <= ST_FINISH;
            end
            ST_FINISH: begin
               if (capture) begin
                  ready_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready   = ready_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.walk    = walk_ff;
   assign cmd.clear   = clear_ff;
   assign cmd.append  = append_ff;
   assign cmd.capture = capture;
   assign cmd.code    = code_ff;

endmodule

// ===== hdl/crs_datapath.sv =====
// keypoint store, pipelined overlap walk, configuration and result registers
`timescale 1ns / 1ps

module crs_datapath import crs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  logic [1:0]               req_func,
   input  logic [COORD_BITS-1:0]    req_x,
   input  logic [COORD_BITS-1:0]    req_y,
   input  logic [RESP_BITS-1:0]     req_response,
   input  logic [ADDR_BITS-1:0]     req_index,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  cmd_type                  cmd,
   output stat_type                 st,
   output logic [2:0]               res_status,
   output logic [CNT_BITS-1:0]      res_kept_count,
   output logic                     res_entry_valid,
   output logic [COORD_BITS-1:0]    res_entry_x,
   output logic [COORD_BITS-1:0]    res_entry_y,
   output logic [RESP_BITS-1:0]     res_entry_response
);

   // latched request
   logic [1:0]            func_ff;
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [RESP_BITS-1:0]  r_ff;
   logic [ADDR_BITS-1:0]  idx_ff;

   // configuration
   logic [RESP_BITS-1:0] min_ff;
   logic [DIAM_BITS-1:0] diam_ff;
   logic [SQ_BITS-1:0]   diam_sq_ff;

   logic [CNT_BITS-1:0] count_ff;

   entry_type            mem [MAX_KEYPOINTS];
   entry_type            rd_data_ff;
   logic [ADDR_BITS-1:0] rd_addr;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] wr_addr;
   entry_type            wr_data;

   // walk pipeline
   logic [CNT_BITS-1:0]   rd_ptr_ff;
   logic                  issue;
   logic                  s1_v_ff;
   logic [ADDR_BITS-1:0]  s1_idx_ff;
   logic                  s2_v_ff;
   logic [ADDR_BITS-1:0]  s2_idx_ff;
   logic [COORD_BITS-1:0] dx_ff;
   logic [COORD_BITS-1:0] dy_ff;
   logic [RESP_BITS-1:0]  s2_r_ff;
   logic                  overlap_ff;
   logic [COORD_BITS-1:0] dx_in;
   logic [COORD_BITS-1:0] dy_in;
   logic [SQ_BITS-1:0]    sq_x;
   logic [SQ_BITS-1:0]    sq_y;
   logic [SQ_BITS:0]      sq_sum;
   logic                  near;
   logic                  hit;
   logic                  entry_valid;

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff <= req_func;
         x_ff    <= req_x;
         y_ff    <= req_y;
         r_ff    <= req_response;
         idx_ff  <= req_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= MIN_RESPONSE_RESET;
         diam_ff    <= KEYPOINT_DIAMETER_RESET;
         diam_sq_ff <= SQ_BITS'(KEYPOINT_DIAMETER_RESET) * SQ_BITS'(KEYPOINT_DIAMETER_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_RESPONSE: begin
               min_ff <= csr_wdata[RESP_BITS-1:0];
            end
            CSR_KEYPOINT_DIAMETER: begin
               diam_ff    <= csr_wdata[DIAM_BITS-1:0];
               diam_sq_ff <= SQ_BITS'(csr_wdata[DIAM_BITS-1:0])
                             * SQ_BITS'(csr_wdata[DIAM_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.clear) begin
         count_ff <= '0;
      end else if (cmd.append) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   // store access
   assign issue   = cmd.walk && !hit && (rd_ptr_ff < count_ff);
   assign rd_addr = cmd.walk ? rd_ptr_ff[ADDR_BITS-1:0] : idx_ff;
   assign mem_we  = hit || cmd.append;
   assign wr_addr = hit ? s2_idx_ff : count_ff[ADDR_BITS-1:0];
   assign wr_data = '{x: x_ff, y: y_ff, r: r_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   // per-axis offsets of the stored entry, registered into stage two
   assign dx_in = (x_ff > rd_data_ff.x) ? x_ff - rd_data_ff.x : rd_data_ff.x - x_ff;
   assign dy_in = (y_ff > rd_data_ff.y) ? y_ff - rd_data_ff.y : rd_data_ff.y - y_ff;

   // squares only matter once both offsets are below the diameter
   assign sq_x   = SQ_BITS'(dx_ff[DIAM_BITS-1:0]) * SQ_BITS'(dx_ff[DIAM_BITS-1:0]);
   assign sq_y   = SQ_BITS'(dy_ff[DIAM_BITS-1:0]) * SQ_BITS'(dy_ff[DIAM_BITS-1:0]);
   assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
   assign near   = s2_v_ff
                   && (dx_ff < COORD_BITS'(diam_ff))
                   && (dy_ff < COORD_BITS'(diam_ff))
                   && (sq_sum < {1'b0, diam_sq_ff});
   assign hit    = cmd.walk && near && (r_ff > s2_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         overlap_ff <= 1'b0;
      end else begin
         rd_ptr_ff  <= !cmd.walk ? '0 : (issue ? rd_ptr_ff + 1'b1 : rd_ptr_ff);
         s1_v_ff    <= issue;
         s2_v_ff    <= cmd.walk && s1_v_ff && !hit;
         overlap_ff <= cmd.walk && (overlap_ff || near);
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= rd_ptr_ff[ADDR_BITS-1:0];
      s2_idx_ff <= s1_idx_ff;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      s2_r_ff   <= rd_data_ff.r;
   end

   assign st.func     = func_ff;
   assign st.below    = (r_ff <= min_ff);
   assign st.hit      = hit;
   assign st.walk_end = (rd_ptr_ff >= count_ff) && !s1_v_ff && !s2_v_ff;
   assign st.overlap  = overlap_ff;
   assign st.full     = (count_ff >= CNT_BITS'(MAX_KEYPOINTS));

   assign entry_valid = (func_ff == FUNC_READ) && (CNT_BITS'(idx_ff) < count_ff);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         res_status         <= cmd.code;
         res_kept_count     <= count_ff;
         res_entry_valid    <= entry_valid;
         res_entry_x        <= entry_valid ? rd_data_ff.x : '0;
         res_entry_y        <= entry_valid ? rd_data_ff.y : '0;
         res_entry_response <= entry_valid ? rd_data_ff.r : '0;
      end
   end

endmodule

// ===== hdl/corner_response_overlap_suppression.sv =====
// top level of the corner response overlap suppression block
//
// Requests arrive on req_chan (valid/ready, transfer when both are high) and
// carry a func code: sample a corner response, read one stored keypoint, or
// clear the store. Every request yields exactly one result on rsp_chan.
// Configuration registers (minimum response, keypoint diameter) are written
// by the user through csr_we/csr_index/csr_wdata only while the block is
// idle; the block itself does not enforce this.
// A read, an unused code or a sample below threshold goes from decode
// straight to its result; a clear passes through the clear state first. A
// sample above threshold walks the kept keypoints through the single store
// read port, one entry per cycle, with a pipelined compare, and an added
// keypoint passes through the append state before its result. The walk
// ends early at the first replaced keypoint.
// One request is in work at a time and the next one can be taken once
// its result is registered, while that result may still sit in the output
// register; a new result waits until rsp_chan.ready takes the old one, so
// nothing is lost when the receiver stalls.
// Reset (synchronous, active high) empties the store and restores register
// defaults; store contents themselves are not cleared.
`timescale 1ns / 1ps

module corner_response_overlap_suppression import crs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   crs_req_if.sink                  req_chan,
   crs_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type st;
   logic     req_ready;
   logic     rsp_valid;
   logic     load;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign load           = req_chan.valid && req_ready;

   crs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   crs_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .req_func           (req_chan.func),
      .req_x              (req_chan.pix_x),
      .req_y              (req_chan.pix_y),
      .req_response       (req_chan.response),
      .req_index          (req_chan.entry_index),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .st                 (st),
      .res_status         (rsp_chan.status),
      .res_kept_count     (rsp_chan.kept_count),
      .res_entry_valid    (rsp_chan.entry_valid),
      .res_entry_x        (rsp_chan.entry_x),
      .res_entry_y        (rsp_chan.entry_y),
      .res_entry_response (rsp_chan.entry_response)
   );

   // no request is taken while the store is being walked
   a_no_accept_in_walk : assert property (@(posedge clock) disable iff (reset)
      cmd.walk |-> !req_ready)
      else $error("request taken during store walk");

   // a store write never coincides with a clear
   a_no_append_on_clear : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !cmd.append && !st.hit)
      else $error("store written during clear");

   // the kept count never passes the store depth
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chan.kept_count <= CNT_BITS'(MAX_KEYPOINTS))
      else $error("kept count beyond store depth");

   // a valid read only comes with the done status
   a_read_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chan.entry_valid |-> rsp_chan.status == STATUS_DONE)
      else $error("read result with wrong status");

   // an added keypoint leaves at least one entry in the store
   a_added_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chan.status == STATUS_ADDED |-> rsp_chan.kept_count != '0)
      else $error("added keypoint with empty store");

endmodule

// ===== sim/tb_corner_response_overlap_suppression.sv =====
// testbench of the corner response overlap suppression block: predicts and checks every result
`timescale 1ns / 1ps

module tb_corner_response_overlap_suppression;
   import crs_pkg::*;

   localparam int CLK_PERIOD = 10;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_STALL = 400;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]            func;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [RESP_BITS-1:0]  resp;
      logic [ADDR_BITS-1:0]  idx;
   } request_type;

   typedef struct packed {
      status_type            status;
      logic [CNT_BITS-1:0]   count;
      logic                  hit;
      entry_type             entry;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   crs_req_if req_chan ();
   crs_rsp_if rsp_chan ();

   // predictor state
   logic [COORD_BITS-1:0] mirror_x [MAX_KEYPOINTS];
   logic [COORD_BITS-1:0] mirror_y [MAX_KEYPOINTS];
   logic [RESP_BITS-1:0]  mirror_resp [MAX_KEYPOINTS];
   int                    kp_total = 0;
   logic [RESP_BITS-1:0]  thr_response;
   logic [DIAM_BITS-1:0]  diam;

   request_type pending[$];
   outcome_type awaited[$];
   logic [2*COORD_BITS-1:0] recent_spots[$];
   request_type offered;
   outcome_type head;
   int mismatch_count = 0;
   int send_idle;
   int recv_idle;
   bit sender_hold;
   int stall_asked;
   int stall_given = 0;
   int stall_left = 0;

   corner_response_overlap_suppression dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic outcome_type predict_outcome(request_type rq);
      outcome_type res;
      int       dx;
      int       dy;
      int       lim;
      int       i;
      bit       overlap;
      bit       stop;
      res = '0;
      res.status = STATUS_DONE;
      if (rq.func == FUNC_SAMPLE) begin
         if (rq.resp <= thr_response) begin
            res.status = STATUS_BELOW;
         end else begin
            lim = int'(diam) * int'(diam);
            overlap = 0;
            stop = 0;
            for (i = 0; i < kp_total && !stop; i++) begin
               dx = int'(rq.x) - int'(mirror_x[ADDR_BITS'(i)]);
               dy = int'(rq.y) - int'(mirror_y[ADDR_BITS'(i)]);
               if (dx * dx + dy * dy < lim) begin
                  overlap = 1;
                  if (rq.resp > mirror_resp[ADDR_BITS'(i)]) begin
                     mirror_x[ADDR_BITS'(i)] = rq.x;
                     mirror_y[ADDR_BITS'(i)] = rq.y;
                     mirror_resp[ADDR_BITS'(i)] = rq.resp;
                     res.status = STATUS_REPLACED;
                     stop = 1;
                  end
               end
            end
            if (!stop) begin
               if (overlap) begin
                  res.status = STATUS_SUPPRESSED;
               end else if (kp_total >= MAX_KEYPOINTS) begin
                  res.status = STATUS_FULL;
               end else begin
                  mirror_x[ADDR_BITS'(kp_total)] = rq.x;
                  mirror_y[ADDR_BITS'(kp_total)] = rq.y;
                  mirror_resp[ADDR_BITS'(kp_total)] = rq.resp;
                  kp_total++;
                  res.status = STATUS_ADDED;
               end
            end
         end
      end else if (rq.func == FUNC_READ) begin
         if (int'(rq.idx) < kp_total) begin
            res.hit = 1'b1;
            res.entry.x = mirror_x[rq.idx];
            res.entry.y = mirror_y[rq.idx];
            res.entry.r = mirror_resp[rq.idx];
         end
      end else if (rq.func == FUNC_CLEAR) begin
         kp_total = 0;
      end
      res.count = CNT_BITS'(kp_total);
      return res;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int       pick;
      int       span;
      logic [2*COORD_BITS-1:0] spot;
      rq.func = FUNC_SAMPLE;
      rq.x = COORD_BITS'($urandom);
      rq.y = COORD_BITS'($urandom);
      rq.resp = RESP_BITS'($urandom);
      rq.idx = ADDR_BITS'($urandom);
      pick = $urandom_range(99);
      if (pick < 74) begin
         // cluster around recent samples so overlaps are common
         if (recent_spots.size() > 0 && $urandom_range(99) < 60) begin
            spot = recent_spots[$urandom_range(recent_spots.size() - 1)];
            span = int'(diam) + 2;
            rq.x = COORD_BITS'(spot[2*COORD_BITS-1:COORD_BITS]
                               + $urandom_range(2 * span) - span);
            rq.y = COORD_BITS'(spot[COORD_BITS-1:0] + $urandom_range(2 * span) - span);
         end
         if ($urandom_range(9) == 0) begin
            rq.resp = RESP_BITS'(thr_response + $urandom_range(1));
         end
         recent_spots.insert(recent_spots.size(), {rq.x, rq.y});
         if (recent_spots.size() > 12) begin
            void'(recent_spots.pop_front());
         end
      end else if (pick < 92) begin
         rq.func = FUNC_READ;
         if ($urandom_range(3) != 0) begin
            rq.idx = ADDR_BITS'($urandom_range(40));
         end
      end else if (pick < 96) begin
         rq.func = FUNC_CLEAR;
      end else begin
         rq.func = FUNC_UNUSED;
      end
      return rq;
   endfunction

   task automatic queue_request(logic [1:0] f, int px, int py, int r, int ix);
      request_type rq;
      rq.func = f;
      rq.x = COORD_BITS'(px);
      rq.y = COORD_BITS'(py);
      rq.resp = RESP_BITS'(r);
      rq.idx = ADDR_BITS'(ix);
      pending.insert(pending.size(), rq);
   endtask

   task automatic run_random(int count);
      repeat (count) pending.insert(pending.size(), random_request());
   endtask

   task automatic write_csr(logic [CSR_IDX_BITS-1:0] index, int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_BITS'(value);
      case (index)
         CSR_MIN_RESPONSE: thr_response = RESP_BITS'(value);
         CSR_KEYPOINT_DIAMETER: diam = DIAM_BITS'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending.size() > 0 || awaited.size() > 0 || req_chan.valid) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.func <= FUNC_SAMPLE;
         req_chan.pix_x <= '0;
         req_chan.pix_y <= '0;
         req_chan.response <= '0;
         req_chan.entry_index <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            awaited.insert(awaited.size(), predict_outcome(offered));
         end
         if (req_chan.valid && !req_chan.ready) begin
            req_chan.valid <= 1'b1;
         end else if (pending.size() > 0 && !sender_hold && $urandom_range(99) >= send_idle) begin
            offered = pending.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.func <= offered.func;
            req_chan.pix_x <= offered.x;
            req_chan.pix_y <= offered.y;
            req_chan.response <= offered.resp;
            req_chan.entry_index <= offered.idx;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver with long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_asked != stall_given) begin
            stall_given++;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited.size() == 0) begin
            $display("%0t: unexpected transfer, status %0d, kept_count %0d", $time,
                     rsp_chan.status, rsp_chan.kept_count);
            mismatch_count++;
         end else begin
            head = awaited.pop_front();
            check_field("status", 32'(head.status), 32'(rsp_chan.status));
            check_field("kept_count", 32'(head.count), 32'(rsp_chan.kept_count));
            check_field("entry_valid", 32'(head.hit), 32'(rsp_chan.entry_valid));
            check_field("entry_x", 32'(head.entry.x), 32'(rsp_chan.entry_x));
            check_field("entry_y", 32'(head.entry.y), 32'(rsp_chan.entry_y));
            check_field("entry_response", 32'(head.entry.r), 32'(rsp_chan.entry_response));
         end
      end
   end

   initial begin
      #60_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      thr_response = MIN_RESPONSE_RESET;
      diam = KEYPOINT_DIAMETER_RESET;
      sender_hold = 0;
      stall_asked = 0;
      send_idle = 19;
      recv_idle = 85;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part on reset settings
      queue_request(FUNC_SAMPLE, 0, 0, 255, 0);
      queue_request(FUNC_SAMPLE, 4095, 4095, 101, 0);
      queue_request(FUNC_SAMPLE, 4095, 0, 100, 0);
      queue_request(FUNC_SAMPLE, 0, 4095, 0, 0);
      queue_request(FUNC_SAMPLE, 3, 3, 200, 0);
      queue_request(FUNC_SAMPLE, 4090, 4095, 150, 0);
      queue_request(FUNC_SAMPLE, 4, 4, 255, 0);
      queue_request(FUNC_SAMPLE, 6, 0, 255, 0);
      queue_request(FUNC_READ, 0, 0, 0, 0);
      queue_request(FUNC_READ, 0, 0, 0, 1);
      queue_request(FUNC_READ, 0, 0, 0, 2);
      queue_request(FUNC_READ, 0, 0, 0, 3);
      queue_request(FUNC_READ, 4095, 4095, 255, 1023);
      queue_request(FUNC_UNUSED, 4095, 4095, 255, 1023);
      queue_request(FUNC_CLEAR, 0, 0, 0, 0);
      queue_request(FUNC_READ, 0, 0, 0, 0);
      // higher stored response first, weaker overlapping samples are suppressed
      queue_request(FUNC_SAMPLE, 100, 100, 250, 0);
      queue_request(FUNC_SAMPLE, 104, 100, 120, 0);
      queue_request(FUNC_SAMPLE, 102, 100, 200, 0);
      queue_request(FUNC_READ, 0, 0, 0, 1);
      queue_request(FUNC_SAMPLE, 2048, 2048, 255, 0);
      queue_request(FUNC_SAMPLE, 2050, 2048, 101, 0);
      run_random(110);
      wait_drained();

      write_csr(CSR_MIN_RESPONSE, 0);
      write_csr(CSR_KEYPOINT_DIAMETER, 63);
      run_random(90);
      wait_drained();

      send_idle = 85;
      recv_idle = 19;
      write_csr(CSR_MIN_RESPONSE, 255);
      write_csr(CSR_KEYPOINT_DIAMETER, 1);
      run_random(30);
      wait_drained();

      write_csr(CSR_MIN_RESPONSE, 50);
      write_csr(CSR_KEYPOINT_DIAMETER, 20);
      run_random(120);
      // sender pause until all results are back
      while (pending.size() > 60) @(negedge clock);
      sender_hold = 1;
      while (awaited.size() > 0 || req_chan.valid) @(negedge clock);
      sender_hold = 0;
      wait_drained();

      send_idle = 0;
      recv_idle = 0;
      write_csr(CSR_MIN_RESPONSE, 128);
      write_csr(CSR_KEYPOINT_DIAMETER, 0);
      run_random(80);
      stall_asked++;
      wait_drained();

      write_csr(CSR_MIN_RESPONSE, 10);
      write_csr(CSR_KEYPOINT_DIAMETER, 8);
      run_random(120);
      wait_drained();

      write_csr(CSR_MIN_RESPONSE, 0);
      write_csr(CSR_KEYPOINT_DIAMETER, 2);
      queue_request(FUNC_SAMPLE, 0, 0, 255, 0);
      queue_request(FUNC_SAMPLE, 64, 0, 1, 0);
      queue_request(FUNC_SAMPLE, 2000, 4000, 200, 0);
      queue_request(FUNC_READ, 0, 0, 0, 0);
      queue_request(FUNC_CLEAR, 0, 0, 0, 0);
      queue_request(FUNC_READ, 0, 0, 0, 0);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== corner_response_overlap_suppression.f =====
hdl/crs_pkg.sv
hdl/crs_if.sv
hdl/crs_ctrl.sv
hdl/crs_datapath.sv
hdl/corner_response_overlap_suppression.sv
sim/tb_corner_response_overlap_suppression.sv
